// ===== sv/afp_pkg.sv =====
// Package for the ASCII motor frame parser: shared item and result types,
// character codes and the minimum frame length. No dependencies.
`default_nettype none

package afp_pkg;

	localparam int unsigned MIN_FRAME_LEN = 14;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_T = 8'h54;

	typedef enum logic [1:0] {
		ST_TOTAL   = 2'd0,
		ST_STEP    = 2'd1,
		ST_BAD_LEN = 2'd2,
		ST_BAD_FMT = 2'd3
	} status_t;

	typedef enum logic {
		KIND_BYTE = 1'b0,
		KIND_ARM  = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] byte_value;
	} item_t;

	typedef struct packed {
		logic                   init_captured;
		status_t                status;
		logic [3:0][31:0]       prior;
		logic [3:0][31:0]       value;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/afp_in_reg.sv =====
// Input register stage of the frame parser: holds one request until the
// parser stage can take it. Depends on afp_pkg.
`default_nettype none

module afp_in_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire afp_pkg::item_t in_item,
	input  wire logic          advance,
	output logic               valid_s1,
	output afp_pkg::item_t     item_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

// ===== sv/afp_parser.sv =====
// Frame parser: framing, prefix check, decimal conversion with saturation and
// count bookkeeping, one character per cycle while fire is high. Depends on afp_pkg.
`default_nettype none

module afp_parser #(
	parameter int unsigned MAX_FRAME_LEN = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           fire,
	input  wire afp_pkg::item_t item,
	output logic                res_valid,
	output afp_pkg::result_t    res
);

	typedef enum logic [2:0] {
		M_IDLE, M_PREFIX, M_NUM_START, M_NUM_SIGN, M_NUM_DIGITS, M_DONE, M_FAIL
	} mode_t;

	localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;

	mode_t            mode_q, mode_d;
	logic             type_q, type_d;
	logic [6:0]       cnt_q, cnt_d;
	logic [1:0]       idx_q, idx_d;
	logic [31:0]      acc_q, acc_d;
	logic             neg_q, neg_d;
	logic             armed_q, armed_d;
	logic [3:0][31:0] staged_q, staged_d;
	logic [3:0][31:0] step_q, step_d;
	logic [3:0][31:0] vals;
	logic [31:0]      fin;
	logic [31:0]      acc_dig;
	logic [7:0]       b;
	logic             is_digit, is_space;

	function automatic logic [7:0] prefix_char(input logic ft, input logic [6:0] pos);
		logic [7:0] c;
		case (pos)
			7'd0: c = 8'h24;                    // $
			7'd1: c = 8'h4D;                    // M
			7'd2: c = ft ? 8'h54 : 8'h41;       // T / A
			7'd3: c = ft ? 8'h45 : 8'h6C;       // E / l
			7'd4: c = ft ? 8'h50 : 8'h6C;       // P / l
			7'd5: c = 8'h3A;                    // :
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [31:0] add_digit(input logic [31:0] a, input logic [3:0] d);
		logic [35:0] t;
		t = ({4'b0, a} << 3) + ({4'b0, a} << 1) + 36'(d);
		return (t > 36'(MAG_LIMIT)) ? MAG_LIMIT : t[31:0];
	endfunction

	assign b        = item.byte_value;
	assign is_digit = (b >= 8'h30) && (b <= 8'h39);
	assign is_space = b inside {8'h20, [8'h09:8'h0D]};
	assign acc_dig  = add_digit(acc_q, b[3:0]);
	// signed finish of the magnitude, clamped at the 32-bit limits
	assign fin = neg_q ? ((acc_q >= MAG_LIMIT) ? MAG_LIMIT : 32'(0) - acc_q)
	                   : ((acc_q >= MAG_LIMIT) ? 32'h7FFF_FFFF : acc_q);

	always_comb begin
		mode_d    = mode_q;
		type_d    = type_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		acc_d     = acc_q;
		neg_d     = neg_q;
		armed_d   = armed_q;
		staged_d  = staged_q;
		step_d    = step_q;
		vals      = staged_q;
		res_valid = 1'b0;
		res       = '0;
		if (fire) begin
			if (item.kind == afp_pkg::KIND_ARM) begin
				armed_d = 1'b1;
			end else if (mode_q == M_IDLE) begin
				if (b == afp_pkg::CH_DOLLAR) begin
					mode_d = M_PREFIX;
					type_d = 1'b0;
					cnt_d  = 7'd1;
					idx_d  = '0;
					acc_d  = '0;
					neg_d  = 1'b0;
				end
			end else if (b != afp_pkg::CH_HASH) begin
				if (cnt_q != '1) begin
					cnt_d = cnt_q + 7'd1;
				end
				case (mode_q)
					M_PREFIX: begin
						if (cnt_q == 7'd2) begin
							if (b == afp_pkg::CH_UPPER_A) begin
								type_d = 1'b0;
							end else if (b == afp_pkg::CH_UPPER_T) begin
								type_d = 1'b1;
							end else begin
								mode_d = M_FAIL;
							end
						end else if (cnt_q < 7'd6 && b != prefix_char(type_q, cnt_q)) begin
							mode_d = M_FAIL;
						end
						if (mode_d == M_PREFIX && cnt_q == 7'd5) begin
							mode_d = M_NUM_START;
							idx_d  = '0;
							acc_d  = '0;
							neg_d  = 1'b0;
						end
					end
					M_NUM_START: begin
						if (is_space) begin
							mode_d = M_NUM_START;
						end else if (b == afp_pkg::CH_PLUS || b == afp_pkg::CH_MINUS) begin
							neg_d  = (b == afp_pkg::CH_MINUS);
							mode_d = M_NUM_SIGN;
						end else if (is_digit) begin
							acc_d  = acc_dig;
							mode_d = M_NUM_DIGITS;
						end else begin
							mode_d = M_FAIL;
						end
					end
					M_NUM_SIGN: begin
						if (is_digit) begin
							acc_d  = acc_dig;
							mode_d = M_NUM_DIGITS;
						end else begin
							mode_d = M_FAIL;
						end
					end
					M_NUM_DIGITS: begin
						if (is_digit) begin
							acc_d = acc_dig;
						end else if (idx_q == 2'd3) begin
							staged_d[3] = fin;
							mode_d      = M_DONE;
						end else if (b == afp_pkg::CH_COMMA) begin
							staged_d[idx_q] = fin;
							idx_d           = idx_q + 2'd1;
							acc_d           = '0;
							neg_d           = 1'b0;
							mode_d          = M_NUM_START;
						end else begin
							mode_d = M_FAIL;
						end
					end
					default: begin
						mode_d = mode_q;
					end
				endcase
			end else begin
				// closing mark: exactly one result per frame
				res_valid = 1'b1;
				if (cnt_q < 7'(afp_pkg::MIN_FRAME_LEN - 1) || cnt_q >= 7'(MAX_FRAME_LEN)) begin
					res.status = afp_pkg::ST_BAD_LEN;
				end else if (mode_q == M_DONE || (mode_q == M_NUM_DIGITS && idx_q == 2'd3)) begin
					if (mode_q == M_NUM_DIGITS) begin
						vals[3] = fin;
					end
					staged_d  = vals;
					res.value = vals;
					if (!type_q) begin
						res.status = afp_pkg::ST_TOTAL;
						if (armed_q) begin
							res.init_captured = 1'b1;
							armed_d           = 1'b0;
						end
					end else begin
						res.status = afp_pkg::ST_STEP;
						res.prior  = step_q;
						step_d     = vals;
					end
				end else begin
					res.status = afp_pkg::ST_BAD_FMT;
				end
				mode_d = M_IDLE;
				cnt_d  = '0;
				idx_d  = '0;
				acc_d  = '0;
				neg_d  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			type_q  <= 1'b0;
			cnt_q   <= '0;
			idx_q   <= '0;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			armed_q <= 1'b0;
			step_q  <= '0;
		end else begin
			mode_q  <= mode_d;
			type_q  <= type_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			armed_q <= armed_d;
			step_q  <= step_d;
		end
	end

	// staged numbers are only read after being written in the same frame
	always_ff @(posedge clk) begin
		staged_q <= staged_d;
	end

endmodule

`default_nettype wire

// ===== sv/afp_out_reg.sv =====
// Result register of the frame parser: holds one result until the sink takes
// it and tells the upstream stages when they may move. Depends on afp_pkg.
`default_nettype none

module afp_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             res_valid,
	input  wire afp_pkg::result_t res,
	output logic                  advance,
	output logic                  out_valid_q,
	input  wire logic             out_ready,
	output afp_pkg::result_t      out_q
);

	assign advance = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

endmodule

`default_nettype wire

// ===== sv/ascii_motor_frame_parser_unit.sv =====
// ASCII motor frame parser, top level. Takes one received character (or an
// arm request) per cycle and emits a status result for every frame closed by
// '#'. Each request passes an input register, the combinational parse logic
// and a result register, and a new request is taken every cycle while the
// result register is free or being drained. Frames run from '$' to '#';
// lengths from 14 to MAX_FRAME_LEN bytes with prefix "$MAll:" or "$MTEP:"
// and four comma-separated decimals are accepted, the rest are reported as
// bad length or bad format.
// Depends on afp_pkg, afp_in_reg, afp_parser and afp_out_reg.
`default_nettype none

module ascii_motor_frame_parser_unit #(
	parameter int unsigned MAX_FRAME_LEN = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,    // [7:0] byte_value
	input  wire logic         s_tuser,    // [0] kind
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [255:0]      m_tdata,    // value_a..value_d, prior_a..prior_d, 32 bits each
	output logic [2:0]        m_tuser     // [1:0] status, [2] init_captured
);

	afp_pkg::item_t   in_item;
	afp_pkg::item_t   item_s1;
	afp_pkg::result_t res;
	afp_pkg::result_t out_q;
	logic             valid_s1;
	logic             advance;
	logic             res_valid;

	assign in_item.kind       = afp_pkg::kind_t'(s_tuser);
	assign in_item.byte_value = s_tdata;

	afp_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	afp_parser #(
		.MAX_FRAME_LEN (MAX_FRAME_LEN)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (valid_s1 && advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	afp_out_reg u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.res_valid   (res_valid),
		.res         (res),
		.advance     (advance),
		.out_valid_q (m_tvalid),
		.out_ready   (m_tready),
		.out_q       (out_q)
	);

	assign m_tdata = {out_q.prior, out_q.value};
	assign m_tuser = {out_q.init_captured, out_q.status};

endmodule

`default_nettype wire

// ===== sv/afp_checker.sv =====
// Port-level checks for the ASCII motor frame parser, bound to the top level.
// Depends on ascii_motor_frame_parser_unit port names.
`default_nettype none

module afp_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic [7:0]   s_tdata,
	input wire logic         s_tuser,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [255:0] m_tdata,
	input wire logic [2:0]   m_tuser
);

	// a stalled result stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// rejected frames carry no counts and no capture flag
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata == '0 && !m_tuser[2])
		else $error("rejected frame carries data");

	// total frames report no prior step counts
	a_total_prior: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == 2'd0 |-> m_tdata[255:128] == '0)
		else $error("total frame carries prior counts");

	// only a total frame may capture initial counts
	a_capture_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tuser[1:0] == 2'd0)
		else $error("capture flag on non-total frame");

	// an arm request passes the parse stage on the next free cycle and loads an empty
	// result register
	a_arm_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser ##1 (!m_tvalid || m_tready) |=> !m_tvalid)
		else $error("arm request produced a result");

endmodule

bind ascii_motor_frame_parser_unit afp_checker u_afp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
